/* sv/chacha_pkg.sv */
// shared types, constants and helpers of the chacha20 stream xor block
`timescale 1ns / 1ps

package chacha_pkg;

  // block geometry
  localparam int unsigned BlockWords   = 16;
  localparam int unsigned BlockBytes   = 64;
  localparam int unsigned DoubleRounds = 10;
  // two half quarter-rounds per quarter, eight quarters per double round
  localparam int unsigned HalfSteps    = 16;
  localparam int unsigned RoundCycles  = DoubleRounds * HalfSteps;

  // "expand 32-byte k"
  localparam logic [31:0] Sigma [4] = '{
    32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
  };

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_READ,
    ST_OUT
  } state_e;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_KEY_01    = 3'd0,
    REG_KEY_23    = 3'd1,
    REG_KEY_45    = 3'd2,
    REG_KEY_67    = 3'd3,
    REG_NONCE_01  = 3'd4,
    REG_NONCE_2   = 3'd5,
    REG_START_CTR = 3'd6
  } reg_idx_e;

  // rotate left, called with constant amounts only
  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

endpackage

/* sv/chacha20_stream_xor.sv */
// byte-serial chacha20 keystream xor with a shared half quarter-round unit
`timescale 1ns / 1ps

// channel   | dir | handshake                | beat payload
// ----------+-----+--------------------------+---------------------------
// in        | in  | in_valid_i / in_ready_o  | data_byte_i, first_i
// out       | out | out_valid_o / out_ready_i| out_byte_o
// apb       | in  | psel, penable / pready   | paddr, pwdata, prdata
//
// a byte from the current keystream block goes through accept and output load.
// a byte that opens a block (first_i, or 64 bytes used) goes through accept,
// load, the rounds on the shared half quarter-round unit, the final adds
// one word a cycle into the keystream memory, a read, and output load.
// the output register lets the next beat in while a result waits to be taken.
// reset: asynchronous, active low; no keystream block held, block counter zero.

module chacha20_stream_xor (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // input stream
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_i,
  // output stream
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o
);

  // configuration registers
  logic [63:0] key01_q, key23_q, key45_q, key67_q, nonce01_q;
  logic [31:0] nonce2_q, start_ctr_q;
  logic        cfg_wr;

  // sequencer and stream state
  chacha_pkg::state_e state_q, state_d;
  logic [7:0]  cyc_q, cyc_d;
  logic [6:0]  pos_q, pos_d;
  logic [31:0] ctr_q, ctr_d;
  logic [7:0]  data_q, data_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;

  // working words and keystream memory
  logic [31:0] w_q [chacha_pkg::BlockWords];
  logic [31:0] w_d [chacha_pkg::BlockWords];
  logic [31:0] w_rnd [chacha_pkg::BlockWords];
  logic [31:0] w_nx [chacha_pkg::BlockWords];
  logic [31:0] init_w [chacha_pkg::BlockWords];
  logic [31:0] ks_mem [chacha_pkg::BlockWords];
  logic [31:0] rd_q;
  logic [31:0] ks_word;
  logic        ks_we, rd_en;

  // quarter-round unit signals
  logic        diag, half;
  logic [31:0] va, vb, vc, vd, a1, b1, c1, d1;
  logic [3:0]  b_idx, c_idx, d_idx;

  // apb register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key01_q     <= '0;
      key23_q     <= '0;
      key45_q     <= '0;
      key67_q     <= '0;
      nonce01_q   <= '0;
      nonce2_q    <= '0;
      start_ctr_q <= 32'd1;
    end else if (cfg_wr) begin
      unique case (chacha_pkg::reg_idx_e'(paddr[5:3]))
        chacha_pkg::REG_KEY_01:    key01_q     <= pwdata;
        chacha_pkg::REG_KEY_23:    key23_q     <= pwdata;
        chacha_pkg::REG_KEY_45:    key45_q     <= pwdata;
        chacha_pkg::REG_KEY_67:    key67_q     <= pwdata;
        chacha_pkg::REG_NONCE_01:  nonce01_q   <= pwdata;
        chacha_pkg::REG_NONCE_2:   nonce2_q    <= pwdata[31:0];
        chacha_pkg::REG_START_CTR: start_ctr_q <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (chacha_pkg::reg_idx_e'(paddr[5:3]))
      chacha_pkg::REG_KEY_01:    prdata = key01_q;
      chacha_pkg::REG_KEY_23:    prdata = key23_q;
      chacha_pkg::REG_KEY_45:    prdata = key45_q;
      chacha_pkg::REG_KEY_67:    prdata = key67_q;
      chacha_pkg::REG_NONCE_01:  prdata = nonce01_q;
      chacha_pkg::REG_NONCE_2:   prdata = {32'd0, nonce2_q};
      chacha_pkg::REG_START_CTR: prdata = {32'd0, start_ctr_q};
      default:                   prdata = '0;
    endcase
  end

  // block input words
  always_comb begin
    init_w[0]  = chacha_pkg::Sigma[0];
    init_w[1]  = chacha_pkg::Sigma[1];
    init_w[2]  = chacha_pkg::Sigma[2];
    init_w[3]  = chacha_pkg::Sigma[3];
    init_w[4]  = key01_q[31:0];
    init_w[5]  = key01_q[63:32];
    init_w[6]  = key23_q[31:0];
    init_w[7]  = key23_q[63:32];
    init_w[8]  = key45_q[31:0];
    init_w[9]  = key45_q[63:32];
    init_w[10] = key67_q[31:0];
    init_w[11] = key67_q[63:32];
    init_w[12] = ctr_q;
    init_w[13] = nonce01_q[31:0];
    init_w[14] = nonce01_q[63:32];
    init_w[15] = nonce2_q;
  end

  // shared half quarter-round unit on fixed taps: column 0,4,8,12 or diagonal 0,5,10,15
  assign diag  = cyc_q[3];
  assign half  = cyc_q[0];
  assign b_idx = diag ? 4'd5  : 4'd4;
  assign c_idx = diag ? 4'd10 : 4'd8;
  assign d_idx = diag ? 4'd15 : 4'd12;

  always_comb begin
    va = w_q[0];
    vb = diag ? w_q[5]  : w_q[4];
    vc = diag ? w_q[10] : w_q[8];
    vd = diag ? w_q[15] : w_q[12];
    a1 = va + vb;
    d1 = half ? chacha_pkg::rotl(vd ^ a1, 8) : chacha_pkg::rotl(vd ^ a1, 16);
    c1 = vc + d1;
    b1 = half ? chacha_pkg::rotl(vb ^ c1, 7) : chacha_pkg::rotl(vb ^ c1, 12);
  end

  // write back the taps, then after a full quarter rotate each row left by one word
  always_comb begin
    w_rnd        = w_q;
    w_rnd[0]     = a1;
    w_rnd[b_idx] = b1;
    w_rnd[c_idx] = c1;
    w_rnd[d_idx] = d1;
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 4; j++) begin
        w_nx[r*4 + j] = half ? w_rnd[r*4 + ((j + 1) % 4)] : w_rnd[r*4 + j];
      end
    end
  end

  // final add of the input words, one word a cycle from the head of the shift
  assign ks_word = w_q[0] + init_w[cyc_q[3:0]];

  // sequencer: next state and datapath control
  always_comb begin
    state_d     = state_q;
    cyc_d       = cyc_q;
    pos_d       = pos_q;
    ctr_d       = ctr_q;
    data_d      = data_q;
    w_d         = w_q;
    out_byte_d  = out_byte_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ks_we       = 1'b0;
    rd_en       = 1'b0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      chacha_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        rd_en      = 1'b1;
        if (in_valid_i) begin
          data_d = data_byte_i;
          if (first_i) begin
            ctr_d = start_ctr_q;
          end
          state_d = (first_i || pos_q[6]) ? chacha_pkg::ST_LOAD : chacha_pkg::ST_OUT;
        end
      end
      chacha_pkg::ST_LOAD: begin
        w_d     = init_w;
        cyc_d   = '0;
        state_d = chacha_pkg::ST_ROUND;
      end
      chacha_pkg::ST_ROUND: begin
        w_d = w_nx;
        if (cyc_q == 8'(chacha_pkg::RoundCycles - 1)) begin
          cyc_d   = '0;
          state_d = chacha_pkg::ST_FINAL;
        end else begin
          cyc_d = cyc_q + 8'd1;
        end
      end
      chacha_pkg::ST_FINAL: begin
        ks_we = 1'b1;
        for (int i = 0; i < chacha_pkg::BlockWords - 1; i++) begin
          w_d[i] = w_q[i + 1];
        end
        if (cyc_q[3:0] == 4'(chacha_pkg::BlockWords - 1)) begin
          cyc_d   = '0;
          ctr_d   = ctr_q + 32'd1;
          pos_d   = '0;
          state_d = chacha_pkg::ST_READ;
        end else begin
          cyc_d = cyc_q + 8'd1;
        end
      end
      chacha_pkg::ST_READ: begin
        rd_en   = 1'b1;
        state_d = chacha_pkg::ST_OUT;
      end
      chacha_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_byte_d  = data_q ^ rd_q[{pos_q[1:0], 3'b000} +: 8];
          out_valid_d = 1'b1;
          pos_d       = pos_q + 7'd1;
          state_d     = chacha_pkg::ST_IDLE;
        end
      end
      default: state_d = chacha_pkg::ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chacha_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyc_q       <= '0;
      pos_q       <= 7'(chacha_pkg::BlockBytes);
      ctr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cyc_q       <= cyc_d;
      pos_q       <= pos_d;
      ctr_q       <= ctr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    data_q     <= data_d;
    out_byte_q <= out_byte_d;
    w_q        <= w_d;
  end

  // keystream memory, one word written and one read per cycle
  always_ff @(posedge clk_i) begin
    if (ks_we) begin
      ks_mem[cyc_q[3:0]] <= ks_word;
    end
    if (rd_en) begin
      rd_q <= ks_mem[pos_q[5:2]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

`ifndef SYNTH
  // an accepted beat goes either to block generation or straight to output
  a_accept_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=>
      (state_q == chacha_pkg::ST_LOAD || state_q == chacha_pkg::ST_OUT))
    else $error("accepted beat took an unexpected path");

  // a finished block restarts the position and advances the counter
  a_block_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == chacha_pkg::ST_FINAL && cyc_q[3:0] == 4'(chacha_pkg::BlockWords - 1) |=>
      pos_q == 7'd0 && ctr_q == 32'($past(ctr_q) + 32'd1))
    else $error("block end did not update position and counter");

  // a result beat is only produced from the output state
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == chacha_pkg::ST_OUT)
    else $error("result raised outside the output state");

  // position never runs past one block
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == chacha_pkg::ST_OUT |-> !pos_q[6])
    else $error("byte read without a valid keystream block");
`endif

endmodule

/* tb/chacha20_keystream_checker.sv */
// checker for the chacha20 stream xor block: keystream prediction and beat compare
`timescale 1ns / 1ps

module chacha20_keystream_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port, watched
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic [63:0] prdata,
  input  logic        pready,
  // input stream, watched
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_i,
  // output stream, watched
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [7:0]  out_byte_o,
  // to the testbench top
  output int          mismatch_count_o,
  output int          pending_o
);

  // "expand 32-byte k", word 0 in the low bits
  localparam logic [127:0] ExpandWords = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };
  localparam int ChainRounds = 10;

  // shadow of the configuration registers
  logic [63:0] key_01, key_23, key_45, key_67, nonce_01;
  logic [31:0] nonce_2, first_counter;

  // running keystream state
  logic [511:0] ks_block;
  logic [6:0]   ks_pos;
  logic [31:0]  blk_ctr;
  logic [7:0]   predicted_cipher [$];
  logic [7:0]   want_byte;
  logic [63:0]  want_reg;
  logic [63:0]  read_mask;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatch_count_o++;
  endtask

  function automatic logic [31:0] rotl_word(input logic [31:0] v, input int n);
    logic [63:0] twice;
    twice = {v, v} << n;
    return twice[63:32];
  endfunction

  // one quarter-round on words a, b, c, d of the packed 16-word state
  function automatic logic [511:0] quarter_mix(input logic [511:0] st,
                                               input int a, input int b,
                                               input int c, input int d);
    logic [31:0] wa, wb, wc, wd;
    wa = st[32*a +: 32];
    wb = st[32*b +: 32];
    wc = st[32*c +: 32];
    wd = st[32*d +: 32];
    wa = wa + wb; wd = rotl_word(wd ^ wa, 16);
    wc = wc + wd; wb = rotl_word(wb ^ wc, 12);
    wa = wa + wb; wd = rotl_word(wd ^ wa, 8);
    wc = wc + wd; wb = rotl_word(wb ^ wc, 7);
    st[32*a +: 32] = wa;
    st[32*b +: 32] = wb;
    st[32*c +: 32] = wc;
    st[32*d +: 32] = wd;
    return st;
  endfunction

  // 64 keystream bytes for one counter value, byte k in bits 8k+7..8k
  function automatic logic [511:0] keystream_block(input logic [31:0] ctr);
    logic [511:0] init_st;
    logic [511:0] st;
    logic [511:0] ks;
    init_st = {nonce_2, nonce_01, ctr, key_67, key_45, key_23, key_01, ExpandWords};
    st = init_st;
    for (int r = 0; r < ChainRounds; r++) begin
      // columns
      st = quarter_mix(st, 0, 4, 8, 12);
      st = quarter_mix(st, 1, 5, 9, 13);
      st = quarter_mix(st, 2, 6, 10, 14);
      st = quarter_mix(st, 3, 7, 11, 15);
      // diagonals
      st = quarter_mix(st, 0, 5, 10, 15);
      st = quarter_mix(st, 1, 6, 11, 12);
      st = quarter_mix(st, 2, 7, 8, 13);
      st = quarter_mix(st, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++)
      ks[32*i +: 32] = st[32*i +: 32] + init_st[32*i +: 32];
    return ks;
  endfunction

  function automatic logic [63:0] reg_shadow(input logic [2:0] idx);
    case (idx)
      chacha_pkg::REG_KEY_01:    return key_01;
      chacha_pkg::REG_KEY_23:    return key_23;
      chacha_pkg::REG_KEY_45:    return key_45;
      chacha_pkg::REG_KEY_67:    return key_67;
      chacha_pkg::REG_NONCE_01:  return nonce_01;
      chacha_pkg::REG_NONCE_2:   return {32'h0, nonce_2};
      chacha_pkg::REG_START_CTR: return {32'h0, first_counter};
      default:                   return 64'h0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_01        = 64'h0;
      key_23        = 64'h0;
      key_45        = 64'h0;
      key_67        = 64'h0;
      nonce_01      = 64'h0;
      nonce_2       = 32'h0;
      first_counter = 32'd1;
      ks_block      = '0;
      ks_pos        = 7'd64;
      blk_ctr       = 32'h0;
      predicted_cipher.delete();
    end else begin
      // register port: track writes, check reads
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[5:3])
            chacha_pkg::REG_KEY_01:    key_01 = pwdata;
            chacha_pkg::REG_KEY_23:    key_23 = pwdata;
            chacha_pkg::REG_KEY_45:    key_45 = pwdata;
            chacha_pkg::REG_KEY_67:    key_67 = pwdata;
            chacha_pkg::REG_NONCE_01:  nonce_01 = pwdata;
            chacha_pkg::REG_NONCE_2:   nonce_2 = pwdata[31:0];
            chacha_pkg::REG_START_CTR: first_counter = pwdata[31:0];
            default: ;  // beyond the register list: no effect
          endcase
        end else if (paddr[5:3] <= chacha_pkg::REG_START_CTR) begin
          want_reg  = reg_shadow(paddr[5:3]);
          read_mask = (paddr[5:3] == chacha_pkg::REG_NONCE_2 ||
                       paddr[5:3] == chacha_pkg::REG_START_CTR) ?
                      64'h0000_0000_ffff_ffff : 64'hffff_ffff_ffff_ffff;
          if ((prdata & read_mask) != want_reg)
            report_mismatch("register readback", prdata & read_mask, want_reg);
        end
      end

      // input beat: restart on message start, new block when the buffer is used up
      if (in_valid_i && in_ready_o) begin
        if (first_i) begin
          blk_ctr = first_counter;
          ks_pos  = 7'd64;
        end
        if (ks_pos >= 7'd64) begin
          ks_block = keystream_block(blk_ctr);
          blk_ctr  = blk_ctr + 32'd1;
          ks_pos   = 7'd0;
        end
        predicted_cipher.push_back(data_byte_i ^ ks_block[8*ks_pos +: 8]);
        ks_pos = ks_pos + 7'd1;
      end

      // output beat: compare with the oldest prediction
      if (out_valid_o && out_ready_i) begin
        if (predicted_cipher.size() == 0) begin
          report_mismatch("out_byte with nothing pending", {56'h0, out_byte_o}, 64'h0);
        end else begin
          want_byte = predicted_cipher.pop_front();
          if (out_byte_o !== want_byte)
            report_mismatch("out_byte", {56'h0, out_byte_o}, {56'h0, want_byte});
        end
      end
    end
    pending_o = predicted_cipher.size();
  end

endmodule

/* tb/tb_chacha20_stream_xor.sv */
// testbench top for the chacha20 stream xor block: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_chacha20_stream_xor;

  localparam logic [2:0] RegBeyondList = 3'd7;
  localparam int Phases        = 10;
  localparam int PhaseItems    = 45;
  localparam int HoldPhase     = 2;
  localparam int PausePhase    = 3;
  localparam int HoldOffCycles = 400;
  localparam int TailCycles    = 200;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        first_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_byte_o;

  int mismatches;
  int pending;
  bit gaps_on       = 1'b1;
  int hold_requests = 0;

  chacha20_stream_xor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .first_i     (first_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o)
  );

  chacha20_keystream_checker u_keystream_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .first_i          (first_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  // 50 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // mostly short idle stretches, now and then a long one
  function automatic int pause_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(15, 60);
    return $urandom_range(0, 3);
  endfunction

  // one register transfer: setup cycle, access cycle, then idle
  task automatic reg_access(input bit write, input logic [2:0] idx,
                            input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // offer one beat and hold it until taken
  task automatic send_byte(input logic [7:0] value, input logic opens);
    int idle;
    if (gaps_on) begin
      idle = pause_len();
      if (idle > 0) begin
        in_valid_i <= 1'b0;
        repeat (idle) @(negedge clk_i);
      end
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= value;
    first_i     <= opens;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // a run of random bytes, optionally opening a message or with stray starts
  task automatic send_run(input int count, input bit opens, input bit noisy);
    for (int i = 0; i < count; i++)
      send_byte(8'($urandom_range(0, 255)),
                (opens && i == 0) || (noisy && $urandom_range(0, 5) == 0));
  endtask

  // stop offering and wait until every predicted byte has come out
  task automatic quiesce();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // receiver: random stalls and ready bursts, plus one long hold-off on request
  initial begin : result_sink
    int stall_left;
    int burst_left;
    int hold_left;
    int hold_seen;
    stall_left  = 0;
    burst_left  = 0;
    hold_left   = 0;
    hold_seen   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_requests != hold_seen) begin
        hold_seen    = hold_requests;
        hold_left    = HoldOffCycles;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        out_ready_i <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(10, 80);
        out_ready_i <= 1'b1;
      end else begin
        stall_left = pause_len();
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int used;
    int n;
    logic [63:0] val;
    bit paused;
    paused      = 1'b0;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    first_i     = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // no message start after reset: stream runs from block counter zero
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h5a, 1'b0);
    quiesce();
    for (int r = 0; r <= chacha_pkg::REG_START_CTR; r++) reg_access(1'b0, r[2:0], 64'h0);

    // key 00..1f, nonce 00 00 00 09 00 00 00 4a 00 00 00 00, counter 1
    reg_access(1'b1, chacha_pkg::REG_KEY_01,    64'h07060504_03020100);
    reg_access(1'b1, chacha_pkg::REG_KEY_23,    64'h0f0e0d0c_0b0a0908);
    reg_access(1'b1, chacha_pkg::REG_KEY_45,    64'h17161514_13121110);
    reg_access(1'b1, chacha_pkg::REG_KEY_67,    64'h1f1e1d1c_1b1a1918);
    reg_access(1'b1, chacha_pkg::REG_NONCE_01,  64'h4a000000_09000000);
    reg_access(1'b1, chacha_pkg::REG_NONCE_2,   64'h0);
    reg_access(1'b1, chacha_pkg::REG_START_CTR, 64'h1);
    reg_access(1'b1, RegBeyondList, 64'hffff_ffff_ffff_ffff);
    for (int r = 0; r <= chacha_pkg::REG_START_CTR; r++) reg_access(1'b0, r[2:0], 64'h0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    // restart in the middle of a block
    send_byte(8'h7f, 1'b1);
    send_byte(8'h33, 1'b0);
    quiesce();
    // counter at its top value
    reg_access(1'b1, chacha_pkg::REG_START_CTR, 64'hffff_ffff);
    send_byte(8'hc3, 1'b1);
    send_byte(8'h3c, 1'b0);

    // random phases, each under its own settings
    for (int ph = 0; ph < Phases; ph++) begin
      quiesce();
      for (int r = 0; r <= chacha_pkg::REG_START_CTR; r++) begin
        if (ph < 2 || $urandom_range(0, 1) == 1) begin
          if (ph == 0)
            val = (r == chacha_pkg::REG_START_CTR) ? 64'hffff_ffff : 64'h0;
          else if (ph == 1)
            val = (r == chacha_pkg::REG_START_CTR) ? 64'h0 : 64'hffff_ffff_ffff_ffff;
          else if (r == chacha_pkg::REG_START_CTR) begin
            case ($urandom_range(0, 3))
              0:       val = 64'h0;
              1:       val = 64'hffff_ffff;
              2:       val = 64'hffff_fff0;
              default: val = {32'h0, $urandom};
            endcase
          end else
            val = {$urandom, $urandom};
          reg_access(1'b1, r[2:0], val);
        end
      end
      if ($urandom_range(0, 2) == 0) reg_access(1'b1, RegBeyondList, {$urandom, $urandom});
      if (ph % 3 == 0)
        for (int r = 0; r <= chacha_pkg::REG_START_CTR; r++)
          reg_access(1'b0, r[2:0], 64'h0);
      // receiver goes quiet while the sender keeps pushing
      if (ph == HoldPhase) hold_requests++;

      used = 0;
      if (ph % 2 == 1) begin
        // carry on the running message under the new key and nonce
        n = $urandom_range(20, 70);
        send_run(n, 1'b0, 1'b0);
        used += n;
      end
      while (used < PhaseItems) begin
        gaps_on = (ph != HoldPhase) && ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 5) == 0) begin
          n = $urandom_range(1, 12);
          send_run(n, 1'b0, 1'b1);
        end else begin
          if (used == 0 && ph < 2)
            n = 130;
          else if ($urandom_range(0, 4) == 0)
            n = $urandom_range(65, 140);
          else
            n = $urandom_range(1, 40);
          send_run(n, 1'b1, 1'b0);
        end
        used += n;
        if (ph == PausePhase && !paused) begin
          quiesce();
          paused = 1'b1;
        end
      end
    end

    // drain, let the pipeline settle, then the verdict
    quiesce();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #25ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
